// File: sv/gmr_pkg.sv
`timescale 1ns / 1ps
// gmr_pkg: shared constants, codes and types for the guest memory region map.
// No dependencies; imported by the region map unit, the result checker and the testbench.
package gmr_pkg;

  // Table depth default
  localparam int unsigned MAX_REGIONS_DEF = 16;

  // Field widths
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned ADDR_W   = 64;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned RIDX_W   = 4;
  localparam int unsigned PSL_W    = 5;

  // Stored entry: base, end (base + size), read-only mark
  localparam int unsigned ENTRY_W = 2 * ADDR_W + 1;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE_LOG2 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDS_ALLOWED   = 2'd1;
  localparam logic [PSL_W-1:0]     PSL_RESET          = 5'd12;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MAP   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BUSY     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_UNMAPPED = 3'd5;

  // One result beat
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [RIDX_W-1:0]   region_index;
    logic [ADDR_W-1:0]   offset;
    logic [ADDR_W-1:0]   granted_length;
    logic                full_span;
  } res_t;

endpackage

// File: sv/guest_memory_region_map_unit.sv
`timescale 1ns / 1ps
// guest_memory_region_map_unit: region table with add, map and clear items.
// Depends on gmr_pkg and gmr_ram.
//
// Channel  | Direction | Handshake              | Beat contents
// ---------+-----------+------------------------+-----------------------------------------
// in       | input     | in_valid_i / in_stall_o | kind, address, length, write_access, read_only
// out      | output    | out_valid_o/out_stall_i | status, region_index, offset, granted_length,
//          |           |                        | full_span
// cfg      | input     | cfg_valid_i/cfg_ready_o | register index, write data
//
// Add: accept, checks in S_PRE and S_TOT, a table walk over the used slots, finish, hand-off.
// Map: accept, a precheck in S_PRE, a walk up to the first hit, then finish, offset, available
// length, grant and hand-off; a miss walks all used slots and goes from finish to hand-off.
// Clear and unknown kinds go from S_PRE straight to hand-off. The walk reads one RAM entry a cycle
// through the single read port, and one shared 65-bit adder does the end, total, offset and available sums.
// Reset empties the table at once (slot count to zero); no clearing pass.
// A result waiting under out_stall_i does not block the next accept; the
// following result waits in its hand-off state until the output register frees.
module guest_memory_region_map_unit #(
  parameter int unsigned MaxRegions = gmr_pkg::MAX_REGIONS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input item channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [gmr_pkg::KIND_W-1:0]       kind_i,
  input  logic [gmr_pkg::ADDR_W-1:0]       address_i,
  input  logic [gmr_pkg::ADDR_W-1:0]       length_i,
  input  logic                             write_access_i,
  input  logic                             read_only_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [gmr_pkg::STATUS_W-1:0]     status_o,
  output logic [gmr_pkg::RIDX_W-1:0]       region_index_o,
  output logic [gmr_pkg::ADDR_W-1:0]       offset_o,
  output logic [gmr_pkg::ADDR_W-1:0]       granted_length_o,
  output logic                             full_span_o,
  // configuration write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [gmr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [gmr_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  import gmr_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxRegions > 1 ? MaxRegions : 2);
  localparam int unsigned CntW = $clog2(MaxRegions + 1);

  // Sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PRE  = 4'd1;
  localparam logic [3:0] S_TOT  = 4'd2;
  localparam logic [3:0] S_WALK = 4'd3;
  localparam logic [3:0] S_FIN  = 4'd4;
  localparam logic [3:0] S_OFF  = 4'd5;
  localparam logic [3:0] S_AVL  = 4'd6;
  localparam logic [3:0] S_GNT  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  // Control state
  logic [3:0]       state_q, state_d;
  logic [CntW-1:0]  used_q, used_d;
  logic [ADDR_W-1:0] total_q, total_d;
  logic [PSL_W-1:0] psl_q, psl_d;
  logic             adds_q, adds_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             rvalid_q, rvalid_d;
  logic             found_q, found_d;
  logic             out_valid_q, out_valid_d;

  // Item and working payload
  logic [KIND_W-1:0] kind_q, kind_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [ADDR_W-1:0] len_q, len_d;
  logic              wr_q, wr_d;
  logic              ro_q, ro_d;
  logic [ADDR_W-1:0] end_q, end_d;
  logic              wrap_q, wrap_d;
  logic [ADDR_W-1:0] tot_new_q, tot_new_d;
  logic [CntW-1:0]   ridx_q, ridx_d;
  logic [ADDR_W-1:0] hit_base_q, hit_base_d;
  logic [ADDR_W-1:0] hit_end_q, hit_end_d;
  logic              hit_lock_q, hit_lock_d;
  logic [CntW-1:0]   hit_idx_q, hit_idx_d;
  logic [ADDR_W-1:0] off_q, off_d;
  logic [ADDR_W-1:0] avail_q, avail_d;
  res_t              res_q, res_d;
  res_t              out_q, out_d;

  // Shared adder
  logic [ADDR_W-1:0] op_a, op_b;
  logic              op_cin;
  logic [ADDR_W:0]   sum;

  // Table RAM ports
  logic               ram_we;
  logic [IdxW-1:0]    ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic [ADDR_W-1:0]  rd_base, rd_end;
  logic               rd_lock;

  // Walk compare unit
  logic              match, hit_now, issue;
  logic [ADDR_W-1:0] mask;
  logic              misaligned;
  logic              accept;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // Shared adder operand select
  always_comb begin
    op_a   = addr_q;
    op_b   = len_q;
    op_cin = 1'b0;
    unique case (state_q)
      S_TOT: begin
        op_a = total_q;
      end
      S_OFF: begin
        op_b   = ~hit_base_q;
        op_cin = 1'b1;
      end
      S_AVL: begin
        op_a   = hit_end_q;
        op_b   = ~addr_q;
        op_cin = 1'b1;
      end
      default: begin
      end
    endcase
  end
  assign sum = {1'b0, op_a} + {1'b0, op_b} + {{ADDR_W{1'b0}}, op_cin};

  // Page alignment of base and size
  assign mask       = (64'd1 << psl_q) - 64'd1;
  assign misaligned = ((addr_q | len_q) & mask) != '0;

  // Entry fields and span compare
  assign rd_base = ram_rdata[ENTRY_W-1 -: ADDR_W];
  assign rd_end  = ram_rdata[ADDR_W:1];
  assign rd_lock = ram_rdata[0];
  always_comb begin
    if (kind_q == KIND_ADD) begin
      match = (addr_q < rd_end) && (rd_base < end_q);
    end else begin
      match = (addr_q >= rd_base) && (addr_q < rd_end);
    end
  end
  assign hit_now = rvalid_q && match;
  assign issue   = (state_q == S_WALK) && (cnt_q != used_q) && !hit_now;

  assign ram_raddr = cnt_q[IdxW-1:0];
  assign ram_waddr = used_q[IdxW-1:0];
  assign ram_wdata = {addr_q, end_q, ro_q};

  // Sequencer
  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    total_d     = total_q;
    psl_d       = psl_q;
    adds_d      = adds_q;
    cnt_d       = cnt_q;
    rvalid_d    = 1'b0;
    found_d     = found_q;
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    addr_d      = addr_q;
    len_d       = len_q;
    wr_d        = wr_q;
    ro_d        = ro_q;
    end_d       = end_q;
    wrap_d      = wrap_q;
    tot_new_d   = tot_new_q;
    ridx_d      = ridx_q;
    hit_base_d  = hit_base_q;
    hit_end_d   = hit_end_q;
    hit_lock_d  = hit_lock_q;
    hit_idx_d   = hit_idx_q;
    off_d       = off_q;
    avail_d     = avail_q;
    res_d       = res_q;
    out_d       = out_q;
    ram_we      = 1'b0;

    // configuration writes
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PAGE_SIZE_LOG2: psl_d  = cfg_data_i[PSL_W-1:0];
        CFG_ADDS_ALLOWED:   adds_d = cfg_data_i[0];
        default: begin
        end
      endcase
    end

    // output register drains on an accepted beat
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          kind_d  = kind_i;
          addr_d  = address_i;
          len_d   = length_i;
          wr_d    = write_access_i;
          ro_d    = read_only_i;
          state_d = S_PRE;
        end
      end

      // end address, map precheck, clear, unknown kinds
      S_PRE: begin
        end_d   = sum[ADDR_W-1:0];
        wrap_d  = sum[ADDR_W];
        res_d   = '0;
        cnt_d   = '0;
        found_d = 1'b0;
        if (kind_q == KIND_ADD) begin
          state_d = S_TOT;
        end else if (kind_q == KIND_MAP) begin
          if (len_q == '0 || sum[ADDR_W]) begin
            res_d.status = ST_INVALID;
            state_d      = S_DONE;
          end else begin
            state_d = S_WALK;
          end
        end else if (kind_q == KIND_CLEAR) begin
          used_d       = '0;
          total_d      = '0;
          res_d.status = ST_OK;
          state_d      = S_DONE;
        end else begin
          res_d.status = ST_INVALID;
          state_d      = S_DONE;
        end
      end

      // add checks in priority order
      S_TOT: begin
        tot_new_d = sum[ADDR_W-1:0];
        priority if (len_q == '0) begin
          res_d.status = ST_INVALID;
          state_d      = S_DONE;
        end else if (!adds_q) begin
          res_d.status = ST_BUSY;
          state_d      = S_DONE;
        end else if (sum[ADDR_W] || wrap_q) begin
          res_d.status = ST_OVERFLOW;
          state_d      = S_DONE;
        end else if (misaligned) begin
          res_d.status = ST_INVALID;
          state_d      = S_DONE;
        end else begin
          state_d = S_WALK;
        end
      end

      // one entry read per cycle, compared in the cycle after its read
      S_WALK: begin
        if (issue) begin
          cnt_d    = cnt_q + CntW'(1);
          rvalid_d = 1'b1;
          ridx_d   = cnt_q;
        end
        if (hit_now) begin
          found_d    = 1'b1;
          hit_base_d = rd_base;
          hit_end_d  = rd_end;
          hit_lock_d = rd_lock;
          hit_idx_d  = ridx_q;
          state_d    = S_FIN;
        end else if (cnt_q == used_q) begin
          state_d = S_FIN;
        end
      end

      S_FIN: begin
        state_d = S_DONE;
        if (kind_q == KIND_ADD) begin
          priority if (found_q) begin
            res_d.status = ST_BUSY;
          end else if (used_q >= CntW'(MaxRegions)) begin
            res_d.status = ST_FULL;
          end else begin
            ram_we             = 1'b1;
            used_d             = used_q + CntW'(1);
            total_d            = tot_new_q;
            res_d.status       = ST_OK;
            res_d.region_index = RIDX_W'(used_q);
          end
        end else begin
          priority if (!found_q) begin
            res_d.status = ST_UNMAPPED;
          end else if (wr_q && hit_lock_q) begin
            res_d.status = ST_INVALID;
          end else begin
            state_d = S_OFF;
          end
        end
      end

      S_OFF: begin
        off_d   = sum[ADDR_W-1:0];
        state_d = S_AVL;
      end

      S_AVL: begin
        avail_d = sum[ADDR_W-1:0];
        state_d = S_GNT;
      end

      // clip request to what is left in the region
      S_GNT: begin
        res_d.status         = ST_OK;
        res_d.region_index   = RIDX_W'(hit_idx_q);
        res_d.offset         = off_q;
        res_d.granted_length = (len_q < avail_q) ? len_q : avail_q;
        res_d.full_span      = (len_q <= avail_q);
        state_d              = S_DONE;
      end

      // hand result to the output register once it is free
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      total_q     <= '0;
      psl_q       <= PSL_RESET;
      adds_q      <= 1'b1;
      cnt_q       <= '0;
      rvalid_q    <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      total_q     <= total_d;
      psl_q       <= psl_d;
      adds_q      <= adds_d;
      cnt_q       <= cnt_d;
      rvalid_q    <= rvalid_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    addr_q     <= addr_d;
    len_q      <= len_d;
    wr_q       <= wr_d;
    ro_q       <= ro_d;
    end_q      <= end_d;
    wrap_q     <= wrap_d;
    tot_new_q  <= tot_new_d;
    ridx_q     <= ridx_d;
    hit_base_q <= hit_base_d;
    hit_end_q  <= hit_end_d;
    hit_lock_q <= hit_lock_d;
    hit_idx_q  <= hit_idx_d;
    off_q      <= off_d;
    avail_q    <= avail_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  // Region table
  gmr_ram #(
    .Width (ENTRY_W),
    .Depth (MaxRegions)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Result ports
  assign out_valid_o      = out_valid_q;
  assign status_o         = out_q.status;
  assign region_index_o   = out_q.region_index;
  assign offset_o         = out_q.offset;
  assign granted_length_o = out_q.granted_length;
  assign full_span_o      = out_q.full_span;

endmodule

// File: sv/gmr_ram.sv
`timescale 1ns / 1ps
// gmr_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module gmr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: test/gmr_result_checker.sv
`timescale 1ns / 1ps
// gmr_result_checker: watches the item, result and register channels of the region map,
// predicts every result beat and compares it with the beat the block delivers.
// Depends on gmr_pkg.
module gmr_result_checker #(
  parameter int unsigned MaxRegions = gmr_pkg::MAX_REGIONS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // item channel
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [gmr_pkg::KIND_W-1:0]     kind_i,
  input  logic [gmr_pkg::ADDR_W-1:0]     address_i,
  input  logic [gmr_pkg::ADDR_W-1:0]     length_i,
  input  logic                           write_access_i,
  input  logic                           read_only_i,
  // result channel
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [gmr_pkg::STATUS_W-1:0]   status_i,
  input  logic [gmr_pkg::RIDX_W-1:0]     region_index_i,
  input  logic [gmr_pkg::ADDR_W-1:0]     offset_i,
  input  logic [gmr_pkg::ADDR_W-1:0]     granted_length_i,
  input  logic                           full_span_i,
  // register channel
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [gmr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gmr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // counters for the top
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             checked_o
);
  import gmr_pkg::*;

  // Shadow copy of the region table and the registers
  logic [ADDR_W-1:0] region_base [MaxRegions];
  logic [ADDR_W-1:0] region_size [MaxRegions];
  logic              region_locked [MaxRegions];
  int unsigned       used_slots;
  logic [ADDR_W-1:0] total_bytes;
  logic [PSL_W-1:0]  page_shift;
  logic              adds_on;

  res_t expected_results [$];
  res_t want_beat;
  res_t got_beat;

  // Work out the result of one item and update the shadow table
  task automatic predict_region_result(input logic [KIND_W-1:0] kind,
                                       input logic [ADDR_W-1:0] addr,
                                       input logic [ADDR_W-1:0] len,
                                       input logic wr, input logic ro,
                                       output res_t r);
    logic [ADDR_W:0]   total_sum;
    logic [ADDR_W:0]   end_sum;
    logic [ADDR_W:0]   slot_end;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] off;
    logic [ADDR_W-1:0] avail;
    logic [ADDR_W-1:0] grant;
    int                hit;
    bit                clash;
    r = '0;
    total_sum = {1'b0, len} + {1'b0, total_bytes};
    end_sum   = {1'b0, addr} + {1'b0, len};
    mask      = (64'd1 << page_shift) - 64'd1;
    case (kind)
      KIND_ADD: begin
        clash = 1'b0;
        for (int i = 0; i < used_slots && i < MaxRegions; i++) begin
          slot_end = {1'b0, region_base[i]} + {1'b0, region_size[i]};
          if ({1'b0, addr} < slot_end && {1'b0, region_base[i]} < end_sum) clash = 1'b1;
        end
        if (len == '0) r.status = ST_INVALID;
        else if (!adds_on) r.status = ST_BUSY;
        else if (total_sum[ADDR_W]) r.status = ST_OVERFLOW;
        else if (end_sum[ADDR_W]) r.status = ST_OVERFLOW;
        else if ((addr & mask) != '0 || (len & mask) != '0) r.status = ST_INVALID;
        else if (clash) r.status = ST_BUSY;
        else if (used_slots >= MaxRegions) r.status = ST_FULL;
        else begin
          region_base[used_slots]   = addr;
          region_size[used_slots]   = len;
          region_locked[used_slots] = ro;
          r.status       = ST_OK;
          r.region_index = used_slots[RIDX_W-1:0];
          used_slots     = used_slots + 1;
          total_bytes    = total_bytes + len;
        end
      end
      KIND_MAP: begin
        hit = -1;
        for (int i = 0; i < used_slots && i < MaxRegions; i++) begin
          if (hit < 0 && addr >= region_base[i] && addr - region_base[i] < region_size[i])
            hit = i;
        end
        if (len == '0 || end_sum[ADDR_W]) r.status = ST_INVALID;
        else if (hit < 0) r.status = ST_UNMAPPED;
        else if (wr && region_locked[hit]) r.status = ST_INVALID;
        else begin
          off   = addr - region_base[hit];
          avail = region_size[hit] - off;
          grant = (len < avail) ? len : avail;
          r.status         = ST_OK;
          r.region_index   = hit[RIDX_W-1:0];
          r.offset         = off;
          r.granted_length = grant;
          r.full_span      = (grant == len);
        end
      end
      KIND_CLEAR: begin
        used_slots  = 0;
        total_bytes = '0;
        r.status    = ST_OK;
      end
      default: r.status = ST_INVALID;
    endcase
  endtask

  // Register writes first, then accepted items, then delivered beats
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_slots   = 0;
      total_bytes  = '0;
      page_shift   = PSL_RESET;
      adds_on      = 1'b1;
      expected_results.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_PAGE_SIZE_LOG2: page_shift = cfg_data_i[PSL_W-1:0];
          CFG_ADDS_ALLOWED:   adds_on    = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        predict_region_result(kind_i, address_i, length_i, write_access_i, read_only_i,
                              want_beat);
        expected_results.push_back(want_beat);
      end
      if (out_valid_i && !out_stall_i) begin
        got_beat.status         = status_i;
        got_beat.region_index   = region_index_i;
        got_beat.offset         = offset_i;
        got_beat.granted_length = granted_length_i;
        got_beat.full_span      = full_span_i;
        checked_o = checked_o + 1;
        if (expected_results.size() == 0) begin
          fail_count_o = fail_count_o + 1;
          if (fail_count_o <= 10)
            $display("%0t: result beat with nothing expected: st=%0d idx=%0d off=%h len=%h",
                     $realtime, got_beat.status, got_beat.region_index, got_beat.offset,
                     got_beat.granted_length);
        end else begin
          want_beat = expected_results.pop_front();
          if (got_beat.status !== want_beat.status ||
              got_beat.region_index !== want_beat.region_index ||
              got_beat.offset !== want_beat.offset ||
              got_beat.granted_length !== want_beat.granted_length ||
              got_beat.full_span !== want_beat.full_span) begin
            fail_count_o = fail_count_o + 1;
            if (fail_count_o <= 10) begin
              $display("%0t: beat %0d exp st=%0d idx=%0d off=%h len=%h full=%0d", $realtime,
                       checked_o, want_beat.status, want_beat.region_index, want_beat.offset,
                       want_beat.granted_length, want_beat.full_span);
              $display("%0t: beat %0d got st=%0d idx=%0d off=%h len=%h full=%0d", $realtime,
                       checked_o, got_beat.status, got_beat.region_index, got_beat.offset,
                       got_beat.granted_length, got_beat.full_span);
            end
          end
        end
      end
      pending_o = expected_results.size();
    end
  end

endmodule

// File: test/guest_memory_region_map_unit_tb.sv
`timescale 1ns / 1ps
// guest_memory_region_map_unit_tb: drives directed and random add/map/clear items and
// register settings into the region map, with random idling on both channels.
// Depends on gmr_pkg, guest_memory_region_map_unit and gmr_result_checker.
module guest_memory_region_map_unit_tb;
  import gmr_pkg::*;

  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 240;
  localparam int CYCLE_LIMIT     = 800000;
  localparam int HOLD_CYCLES     = 400;
  localparam int DRAIN_CYCLES    = 40;
  localparam logic [ADDR_W-1:0] ALL_ONES = '1;

  // Codes with no meaning in the block, used to probe the default paths
  localparam logic [KIND_W-1:0]    KIND_SPARE  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid;
  logic                  in_stall;
  logic [KIND_W-1:0]     kind;
  logic [ADDR_W-1:0]     address;
  logic [ADDR_W-1:0]     length;
  logic                  write_access;
  logic                  read_only;
  logic                  out_valid;
  logic                  out_stall;
  logic [STATUS_W-1:0]   status;
  logic [RIDX_W-1:0]     region_index;
  logic [ADDR_W-1:0]     offset;
  logic [ADDR_W-1:0]     granted_length;
  logic                  full_span;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending;
  int checked;
  int cycle_cnt;
  int items_sent;
  int settings_cnt;

  // Stimulus controls; rx_idle_on and long_hold_req are shared with the stall process
  bit tx_idle_on;
  bit rx_idle_on;
  bit long_hold_req;
  int clear_pct;
  logic [ADDR_W-1:0] page_bytes;
  logic [ADDR_W-1:0] bump_base;
  logic [ADDR_W-1:0] prop_base [$];
  logic [ADDR_W-1:0] prop_size [$];

  guest_memory_region_map_unit u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .kind_i           (kind),
    .address_i        (address),
    .length_i         (length),
    .write_access_i   (write_access),
    .read_only_i      (read_only),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .status_o         (status),
    .region_index_o   (region_index),
    .offset_o         (offset),
    .granted_length_o (granted_length),
    .full_span_o      (full_span),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  gmr_result_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .kind_i           (kind),
    .address_i        (address),
    .length_i         (length),
    .write_access_i   (write_access),
    .read_only_i      (read_only),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .status_i         (status),
    .region_index_i   (region_index),
    .offset_i         (offset),
    .granted_length_i (granted_length),
    .full_span_i      (full_span),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .checked_o        (checked)
  );

  // Clock
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Run limit
  initial cycle_cnt = 0;
  always @(posedge clk_i) begin
    cycle_cnt = cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("guest_memory_region_map_unit_tb failed");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic logic [ADDR_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // A random whole number of pages
  function automatic logic [ADDR_W-1:0] rand_pages(input int lo, input int hi);
    return page_bytes * ADDR_W'($urandom_range(lo, hi));
  endfunction

  // Result side stall: random runs, plus one long hold on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk_i);
      end else if (rx_idle_on && $urandom_range(0, 99) < 30) begin
        out_stall <= 1'b1;
        repeat (($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 60))
          @(posedge clk_i);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk_i);
      end
    end
  end

  // One item beat; valid stays high into the next call when there is no gap
  task automatic send_item(input logic [KIND_W-1:0] k, input logic [ADDR_W-1:0] a,
                           input logic [ADDR_W-1:0] l, input logic wr, input logic ro);
    int gap;
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid     <= 1'b1;
    kind         <= k;
    address      <= a;
    length       <= l;
    write_access <= wr;
    read_only    <= ro;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    items_sent = items_sent + 1;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait until every expected beat has come back
  task automatic wait_drained(input int extra);
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  function automatic logic [ADDR_W-1:0] fresh_bump();
    return rand_pages(0, 255);
  endfunction

  // One random item: mostly well-formed adds and aimed maps, some clears and noise
  task automatic random_item();
    int                r;
    int                sel;
    int                pick;
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] l;
    logic [ADDR_W-1:0] sz;
    r = $urandom_range(0, 99);
    if (r < clear_pct) begin
      bump_base = fresh_bump();
      prop_base.delete();
      prop_size.delete();
      send_item(KIND_CLEAR, rand64(), rand64(), rand_bit(), rand_bit());
    end else if (r < 45) begin
      sel = $urandom_range(0, 9);
      if (sel < 6) begin
        // back-to-back regions that never overlap each other
        a = bump_base;
        l = rand_pages(1, 8);
        bump_base = bump_base + l +
                    (($urandom_range(0, 3) == 0) ? rand_pages(1, 4) : '0);
      end else if (sel < 8) begin
        a = rand_pages(0, 300);
        l = rand_pages(1, 16);
      end else if (sel == 8) begin
        a = rand_pages(0, 300);
        l = rand_pages(1, 4);
        if (page_bytes > 64'd1) begin
          if (rand_bit()) a = a + ADDR_W'($urandom_range(1, 255)) % page_bytes;
          else l = l + ADDR_W'($urandom_range(1, 255)) % page_bytes;
        end else begin
          l = '0;
        end
      end else begin
        a = rand64() & ~(page_bytes - 64'd1);
        l = rand_pages(1, 4);
      end
      if (prop_base.size() >= 32) begin
        void'(prop_base.pop_front());
        void'(prop_size.pop_front());
      end
      prop_base.push_back(a);
      prop_size.push_back(l);
      send_item(KIND_ADD, a, l, rand_bit(), rand_bit());
    end else if (r < 85 && prop_base.size() > 0) begin
      // map aimed at or just past a proposed region
      pick = $urandom_range(0, prop_base.size() - 1);
      sz = prop_size[pick];
      a = prop_base[pick] + rand64() % (sz + (sz >> 2) + 64'd1);
      sel = $urandom_range(0, 9);
      if (sel < 5) l = rand_bit() ? ADDR_W'($urandom_range(1, 256)) : rand_pages(1, 4);
      else if (sel < 8) l = rand64() % (sz + 64'd1) + 64'd1;
      else if (sel == 8) l = '0;
      else l = rand64();
      send_item(KIND_MAP, a, l, rand_bit(), rand_bit());
    end else begin
      l = rand_bit() ? rand64() : {32'h0, $urandom};
      send_item(KIND_W'($urandom_range(0, 3)), rand64(), l, rand_bit(), rand_bit());
    end
  endtask

  // Per-phase register settings and idling
  int psl_tab [NUM_PHASES]   = '{0, 31, 30, 12, 1, 20, 16, 0};
  bit adds_tab [NUM_PHASES]  = '{1, 1, 1, 1, 0, 1, 1, 1};
  int clear_tab [NUM_PHASES] = '{3, 1, 5, 2, 4, 8, 2, 3};

  initial begin
    rst_ni        = 1'b0;
    in_valid      = 1'b0;
    kind          = KIND_ADD;
    address       = '0;
    length        = '0;
    write_access  = 1'b0;
    read_only     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_PAGE_SIZE_LOG2;
    cfg_data      = '0;
    items_sent    = 0;
    settings_cnt  = 1;
    tx_idle_on    = 1'b1;
    rx_idle_on    = 1'b1;
    long_hold_req = 1'b0;
    clear_pct     = 3;
    page_bytes    = 64'd1 << PSL_RESET;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed part at reset settings (4 KiB pages, adds allowed)
    send_item(KIND_MAP, 64'h0, 64'h10, 1'b0, 1'b0);                  // empty table
    send_item(KIND_ADD, 64'h0, 64'h0, 1'b0, 1'b0);                   // zero size
    send_item(KIND_ADD, 64'h1000, 64'h1000, 1'b0, 1'b0);             // slot 0
    send_item(KIND_ADD, 64'h1001, 64'h1000, 1'b0, 1'b0);             // base misaligned
    send_item(KIND_ADD, 64'h3000, 64'h1800, 1'b0, 1'b0);             // size misaligned
    send_item(KIND_ADD, 64'h1000, 64'h2000, 1'b0, 1'b0);             // overlap
    send_item(KIND_ADD, 64'h2000, 64'h2000, 1'b0, 1'b1);             // adjacent, read-only
    send_item(KIND_ADD, ALL_ONES - 64'hFFF, 64'h2000, 1'b0, 1'b0);    // wraps past top
    send_item(KIND_ADD, ALL_ONES - 64'hFFF, 64'h1000, 1'b0, 1'b0);    // ends at top
    send_item(KIND_ADD, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 1'b0, 1'b0);
    send_item(KIND_ADD, 64'h0, 64'hFFFF_FFFF_FFFF_D000, 1'b0, 1'b0);  // total too big
    send_item(KIND_MAP, 64'h1800, 64'h100, 1'b1, 1'b0);              // inside, full span
    send_item(KIND_MAP, 64'h1800, 64'h1000, 1'b0, 1'b0);             // clipped
    send_item(KIND_MAP, 64'h2000, 64'h10, 1'b1, 1'b0);               // write to read-only
    send_item(KIND_MAP, 64'h2000, 64'h10, 1'b0, 1'b0);               // read of read-only
    send_item(KIND_MAP, ALL_ONES, 64'h1, 1'b0, 1'b0);                // request wraps
    send_item(KIND_MAP, ALL_ONES - 64'h1, 64'h1, 1'b1, 1'b1);        // last byte region
    send_item(KIND_MAP, 64'h5000, 64'h0, 1'b0, 1'b0);                // zero length
    send_item(KIND_MAP, 64'h9000, 64'h10, 1'b0, 1'b0);               // hole
    send_item(KIND_MAP, 64'h0, ALL_ONES, 1'b0, 1'b0);                // whole space, no hit
    send_item(KIND_MAP, 64'h1000, ALL_ONES, 1'b0, 1'b0);             // wraps
    send_item(KIND_SPARE, rand64(), rand64(), 1'b1, 1'b1);           // unknown kind
    send_item(KIND_CLEAR, 64'h0, 64'h0, 1'b0, 1'b0);
    send_item(KIND_MAP, 64'h1800, 64'h10, 1'b0, 1'b0);               // gone after clear

    // Random phases, each under its own register settings
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      in_valid <= 1'b0;
      wait_drained(6);
      if (ph == NUM_PHASES - 1) psl_tab[ph] = $urandom_range(2, 29);
      write_reg(CFG_PAGE_SIZE_LOG2,
                CFG_DATA_W'({$urandom, 5'd0}) | CFG_DATA_W'(psl_tab[ph]));
      write_reg(CFG_ADDS_ALLOWED,
                CFG_DATA_W'({$urandom, 1'b0}) | CFG_DATA_W'(adds_tab[ph]));
      if (ph == 5) begin
        write_reg(CFG_SPARE_2, $urandom);
        write_reg(CFG_SPARE_3, $urandom);
      end
      settings_cnt = settings_cnt + 1;
      page_bytes = 64'd1 << psl_tab[ph];
      bump_base  = fresh_bump();
      prop_base.delete();
      prop_size.delete();
      clear_pct  = clear_tab[ph];
      tx_idle_on = (ph != 2);
      rx_idle_on = (ph != 2);
      if (ph == 3) long_hold_req = 1'b1;
      repeat (ITEMS_PER_PHASE) random_item();
    end
    in_valid <= 1'b0;

    // Drain and verdict
    wait_drained(DRAIN_CYCLES);
    $display("Sent %0d items under %0d register settings, one long output hold included.",
             items_sent, settings_cnt);
    $display("Checked %0d result beats, %0d mismatching.", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("guest_memory_region_map_unit_tb passed");
    end else begin
      $display("guest_memory_region_map_unit_tb failed");
    end
    $finish;
  end

endmodule
